// File: design/stxdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stxdf_pkg;

	// start-of-frame marker
	localparam logic [7:0] STX_BYTE = 8'h02;

	// deframer phase codes
	localparam logic [2:0] PH_HUNT     = 3'd0;
	localparam logic [2:0] PH_LEN_H    = 3'd1;
	localparam logic [2:0] PH_LEN_L    = 3'd2;
	localparam logic [2:0] PH_STATUS   = 3'd3;
	localparam logic [2:0] PH_PAYLOAD  = 3'd4;
	localparam logic [2:0] PH_CHECK    = 3'd5;
	localparam logic [2:0] PH_ZERO_END = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
	localparam logic [1:0] KIND_END       = 2'd1;
	localparam logic [1:0] KIND_BAD_START = 2'd2;
	localparam logic [1:0] KIND_ZERO_LEN  = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  pbyte;
		logic [7:0]  status;
		logic [15:0] plen;
	} result_t;

endpackage

`default_nettype wire

// File: design/stx_length_response_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        receive    in_valid / in_stall  rx_byte[7:0]
// out       send       out_valid/ out_stall out_kind[1:0], payload_byte[7:0],
//                                           status_code[7:0], payload_length[15:0]
//
// One word in per cycle while no result is held with out_stall high. A word is
// captured in the input register (_s1) and, on the next advancing cycle, the phase
// machine consumes it and loads the result register.
// arst_n clears valid flags and the frame state (hunting for STX).
// The whole pipe advances unless a result is held with out_stall high; then
// in_stall is raised and both registers hold.

module stx_length_response_deframer
	import stxdf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       out_kind,
	output logic [7:0]       payload_byte,
	output logic [7:0]       status_code,
	output logic [15:0]      payload_length
);

	// pipeline advance: only a held result blocks progress
	logic advance;
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// frame state
	logic [2:0]  phase_q;
	logic [7:0]  length_high_q;
	logic [15:0] bytes_left_q;
	logic [7:0]  frame_status_q;
	logic [15:0] frame_length_q;

	logic [2:0]  phase_d;
	logic [7:0]  length_high_d;
	logic [15:0] bytes_left_d;
	logic [7:0]  frame_status_d;
	logic [15:0] frame_length_d;
	logic        emit;
	result_t     res;
	logic [15:0] len;
	logic [15:0] left_dec;

	assign len      = {length_high_q, byte_s1};
	assign left_dec = bytes_left_q - 16'd1;

	always_comb begin
		phase_d        = phase_q;
		length_high_d  = length_high_q;
		bytes_left_d   = bytes_left_q;
		frame_status_d = frame_status_q;
		frame_length_d = frame_length_q;
		emit           = 1'b0;
		res            = '0;
		unique case (phase_q)
			PH_LEN_H: begin
				length_high_d = byte_s1;
				phase_d       = PH_LEN_L;
			end
			PH_LEN_L: begin
				if (len == 16'd0) begin
					// zero length: no status byte, next word closes it as malformed
					phase_d = PH_ZERO_END;
				end else begin
					// length counts the status byte, so payload is one less
					frame_length_d = len - 16'd1;
					bytes_left_d   = len - 16'd1;
					phase_d        = PH_STATUS;
				end
			end
			PH_STATUS: begin
				frame_status_d = byte_s1;
				phase_d        = (bytes_left_q == 16'd0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				bytes_left_d = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = PH_CHECK;
				end
				emit      = 1'b1;
				res.kind  = KIND_PAYLOAD;
				res.pbyte = byte_s1;
			end
			PH_CHECK: begin
				// trailing check byte is consumed unchecked
				phase_d    = PH_HUNT;
				emit       = 1'b1;
				res.kind   = KIND_END;
				res.status = frame_status_q;
				res.plen   = frame_length_q;
			end
			PH_ZERO_END: begin
				phase_d  = PH_HUNT;
				emit     = 1'b1;
				res.kind = KIND_ZERO_LEN;
			end
			default: begin
				// hunting, and unused codes behave the same
				if (byte_s1 == STX_BYTE) begin
					phase_d = PH_LEN_H;
				end else begin
					phase_d  = PH_HUNT;
					emit     = 1'b1;
					res.kind = KIND_BAD_START;
				end
			end
		endcase
	end

	logic step;
	assign step = advance && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			length_high_q  <= 8'd0;
			bytes_left_q   <= 16'd0;
			frame_status_q <= 8'd0;
			frame_length_q <= 16'd0;
		end else if (step) begin
			phase_q        <= phase_d;
			length_high_q  <= length_high_d;
			bytes_left_q   <= bytes_left_d;
			frame_status_q <= frame_status_d;
			frame_length_q <= frame_length_d;
		end
	end

	// result register
	logic    out_valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = res_q.kind;
	assign payload_byte   = res_q.pbyte;
	assign status_code    = res_q.status;
	assign payload_length = res_q.plen;

endmodule

`default_nettype wire
